[design/fixed_point_divider_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point divider
// Concurrent assertion wrappers; they compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_DIVIDER_DEFINES_SVH
`define FIXED_POINT_DIVIDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge, switched off while reset is asserted.
`define FPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FPD_ASSERT(label, clk, rst_n, prop, msg)
`define FPD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[design/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-point divider package
// Number format, pipeline depth and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

    // Operand format: DATA_WIDTH bits, FRAC_BITS of them fraction bits.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Width of the ports' numeric fields.
    localparam int FIELD_W = 32;

    // Width of the shifted dividend magnitude, and so of the quotient
    // magnitude; the pipeline resolves one quotient bit per stage.
    localparam int NUM_W = DATA_WIDTH + FRAC_BITS;

    // Smallest quotient magnitude that no longer fits as a positive value.
    localparam logic [NUM_W-1:0] SIGN_Q  = NUM_W'(1) << (DATA_WIDTH - 1);
    localparam logic [NUM_W-1:0] MAX_POS = SIGN_Q - NUM_W'(1);

    typedef struct packed {
        logic                divide_by_zero;
        logic                overflow;
        logic [FIELD_W-1:0]  quotient;
    } res_t;

endpackage

`default_nettype wire

[design/fixed_point_divider.sv]
// ----------------------------------------------------------------------------
// Fixed-point divider
// Signed Q16.16 division, fully pipelined with one quotient bit per stage.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                     Word contents (lowest bit first)
//  -------   ------------------------  ---------------------------------------
//  input     s_tvalid/s_tready/s_tdata dividend [31:0], divisor [63:32]
//  result    m_tvalid/m_tready/m_tdata quotient [31:0]
//            m_tuser                   overflow [0], divide_by_zero [1]
//
//  A division enters in every cycle while s_tready is high. A word passes
//  through one operand stage, one restoring compare-and-subtract stage for
//  each of the NUM_W quotient bits (NUM_W is 48 at Q16.16), and the
//  output register that applies the sign and the flags.
//  aresetn is synchronous and active low; it empties the pipeline and the
//  output side, and no clearing pass follows.
//  When the result side stalls, one more word drops into a skid register
//  behind the output register; only then does the whole pipeline hold, and
//  s_tready falls. Nothing is lost or repeated across a stall.
//
`default_nettype none

`include "fixed_point_divider_defines.svh"

module fixed_point_divider
    import fpd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [2*FIELD_W-1:0] s_tdata,   // dividend [31:0], divisor [63:32]

    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [FIELD_W-1:0]   m_tdata,   // quotient [31:0]
    output      logic [7:0]           m_tuser    // overflow [0], divide_by_zero [1], zero
);

    // Pipeline registers. Index 0 holds the operand stage; index k holds the
    // item after k quotient bits have been decided.
    logic                   valid_reg [0:NUM_W];
    logic                   valid_next[0:NUM_W];
    logic [NUM_W-1:0]       nq_reg    [0:NUM_W];   // dividend bits out at the top,
    logic [NUM_W-1:0]       nq_next   [0:NUM_W];   // quotient bits in at the bottom
    logic [DATA_WIDTH-1:0]  rem_reg   [0:NUM_W];
    logic [DATA_WIDTH-1:0]  rem_next  [0:NUM_W];
    logic [DATA_WIDTH-1:0]  den_reg   [0:NUM_W];
    logic [DATA_WIDTH-1:0]  den_next  [0:NUM_W];
    logic                   neg_reg   [0:NUM_W];
    logic                   neg_next  [0:NUM_W];
    logic                   dbz_reg   [0:NUM_W];
    logic                   dbz_next  [0:NUM_W];

    // Output register and skid register.
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;

    logic advance;     // the whole pipeline shifts by one stage
    logic take;        // the output register can load a word
    logic tail_move;   // a finished division leaves the last stage
    res_t tail_res;

    // The pipeline only holds when the skid register is occupied, so the
    // input side keeps flowing through a one-word stall at the output.
    assign advance   = !skid_valid_reg;
    assign s_tready  = advance;
    assign take      = m_tready || !out_valid_reg;
    assign tail_move = advance && valid_reg[NUM_W];

    // ------------------------------------------------------------------
    // Operand stage and division stages.
    // ------------------------------------------------------------------
    always_comb begin
        logic [DATA_WIDTH-1:0] a_raw;
        logic [DATA_WIDTH-1:0] b_raw;
        logic [DATA_WIDTH-1:0] a_mag;
        logic [DATA_WIDTH-1:0] b_mag;
        logic [DATA_WIDTH:0]   r_shift;
        logic [DATA_WIDTH:0]   diff;
        logic                  ge;

        // Only the low DATA_WIDTH bits of each operand take part.
        a_raw = s_tdata[DATA_WIDTH-1:0];
        b_raw = s_tdata[FIELD_W+DATA_WIDTH-1:FIELD_W];
        a_mag = a_raw[DATA_WIDTH-1] ? (~a_raw + DATA_WIDTH'(1)) : a_raw;
        b_mag = b_raw[DATA_WIDTH-1] ? (~b_raw + DATA_WIDTH'(1)) : b_raw;

        valid_next[0] = s_tvalid;
        nq_next[0]    = NUM_W'(a_mag) << FRAC_BITS;
        rem_next[0]   = '0;
        den_next[0]   = b_mag;
        neg_next[0]   = a_raw[DATA_WIDTH-1] ^ b_raw[DATA_WIDTH-1];
        dbz_next[0]   = (b_raw == '0);

        // Each stage brings down the next dividend bit and keeps the trial
        // difference when it does not go negative.
        for (int i = 0; i < NUM_W; i++) begin
            r_shift = {rem_reg[i], nq_reg[i][NUM_W-1]};
            diff    = r_shift - {1'b0, den_reg[i]};
            ge      = (r_shift >= {1'b0, den_reg[i]});

            valid_next[i+1] = valid_reg[i];
            rem_next[i+1]   = ge ? diff[DATA_WIDTH-1:0] : r_shift[DATA_WIDTH-1:0];
            nq_next[i+1]    = {nq_reg[i][NUM_W-2:0], ge};
            den_next[i+1]   = den_reg[i];
            neg_next[i+1]   = neg_reg[i];
            dbz_next[i+1]   = dbz_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // Sign, wrap and flags of the item in the last stage.
    // ------------------------------------------------------------------
    always_comb begin
        logic [NUM_W-1:0]             q;
        logic [NUM_W-1:0]             q_signed;
        logic signed [DATA_WIDTH-1:0] q_low;

        q        = nq_reg[NUM_W];
        q_signed = neg_reg[NUM_W] ? (~q + NUM_W'(1)) : q;
        q_low    = signed'(q_signed[DATA_WIDTH-1:0]);

        if (dbz_reg[NUM_W]) begin
            tail_res.quotient       = '0;
            tail_res.overflow       = 1'b0;
            tail_res.divide_by_zero = 1'b1;
        end else begin
            // A negative quotient may reach the most negative value itself.
            tail_res.quotient       = FIELD_W'(q_low);
            tail_res.overflow       = neg_reg[NUM_W] ? (q > SIGN_Q) : (q > MAX_POS);
            tail_res.divide_by_zero = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid register behind it.
    // ------------------------------------------------------------------
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = tail_move;
                out_next        = tail_res;
            end
        end else if (tail_move) begin
            skid_valid_next = 1'b1;
            skid_next       = tail_res;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NUM_W; i++) begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                for (int i = 0; i <= NUM_W; i++) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i <= NUM_W; i++) begin
                nq_reg[i]  <= nq_next[i];
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_next[i];
                neg_reg[i] <= neg_next[i];
                dbz_reg[i] <= dbz_next[i];
            end
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.quotient;
    assign m_tuser  = {6'b0, out_reg.divide_by_zero, out_reg.overflow};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `FPD_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg, "skid word without an output word")
    `FPD_ASSERT(a_skid_fill_on_stall, aclk, aresetn, $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready), "skid filled while the output was free")
    `FPD_ASSERT(a_skid_holds, aclk, aresetn, (skid_valid_reg && !m_tready) |=> skid_valid_reg, "skid word dropped during a stall")
    `FPD_ASSERT(a_dbz_result, aclk, aresetn, (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]), "zero divisor gave a nonzero result")

endmodule

`default_nettype wire
